FILE: design/flpa_pkg.sv
// Shared constants, types and helpers of the free-list pool allocator.
`default_nettype none
package flpa_pkg;

  localparam int POOL_ADDR_BITS = 16;
  localparam int ADDR_W     = POOL_ADDR_BITS;
  localparam int SIZE_W     = ADDR_W + 1;
  localparam int REQ_W      = 16;
  localparam int ALIGN_W    = 4;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int PAD_W      = 10;

  localparam int DEF_MAX_FREE_BLOCKS = 32;
  localparam int DEF_MAX_ALLOCATIONS = 32;
  localparam int DEF_HEADER_BYTES    = 8;

  localparam logic [REQ_W-1:0]   MIN_REQUEST    = REQ_W'(8);
  localparam logic [ALIGN_W-1:0] MAX_ALIGN_LOG2 = ALIGN_W'(8);
  localparam logic [SIZE_W-1:0]  POOL_MIN       = SIZE_W'(16);
  localparam logic [SIZE_W-1:0]  POOL_MAX       = SIZE_W'(1) << ADDR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_RESTORE = 2'd2,
    MODE_NOP     = 2'd3
  } flpa_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_SMALL   = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } flpa_status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_CHK, S_A_SCAN, S_A_SPLIT, S_SHDN, S_A_REC,
    S_F_LOOK, S_F_POS, S_F_MERGE, S_SHUP, S_F_INS, S_F_FIN, S_RESTORE, S_DONE
  } flpa_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } flpa_fentry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] data;
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } flpa_aentry_t;

  typedef struct packed {
    logic         latch_in;
    logic         init_pool;
    logic         fit_start;
    logic         fit_run;
    logic         split;
    logic         shdn_run;
    logic         rec_wr;
    logic         look_start;
    logic         look_run;
    logic         pos_start;
    logic         pos_run;
    logic         merge_both;
    logic         merge_prev;
    logic         merge_next;
    logic         shup_setup;
    logic         shup_run;
    logic         ins_wr;
    logic         fin;
    logic         set_status;
    flpa_status_t status;
    logic         emit;
  } flpa_cmd_t;

  typedef struct packed {
    logic req_small;
    logic alloc_full;
    logic fit_done;
    logic fit_ok;
    logic left_zero;
    logic shdn_done;
    logic look_done;
    logic look_hit;
    logic pos_done;
    logic mprev;
    logic mnext;
    logic free_full;
    logic shup_done;
    logic out_free;
  } flpa_sts_t;

  // Header plus alignment padding in front of a block start.
  function automatic logic [PAD_W-1:0] flpa_pad(input logic [ADDR_W-1:0]  start,
                                                input logic [ALIGN_W-1:0] lg,
                                                input logic [PAD_W-1:0]   hdr);
    logic [PAD_W-1:0] a;
    logic [PAD_W-1:0] pad0;
    logic [PAD_W-1:0] short;
    logic [PAD_W-1:0] k;
    a     = PAD_W'(1) << lg;
    pad0  = a - (start[PAD_W-1:0] & (a - PAD_W'(1)));
    short = hdr - pad0;
    k     = (short + a - PAD_W'(1)) >> lg;
    if (pad0 < hdr) begin
      return pad0 + (k << lg);
    end
    return pad0;
  endfunction

endpackage
`default_nettype wire

FILE: design/flpa_ifs.sv
// Request and result channel interfaces.
`default_nettype none
interface flpa_in_if;
  logic                               valid;
  logic                               ready;
  logic [flpa_pkg::MODE_W-1:0]        mode;
  logic [flpa_pkg::REQ_W-1:0]         request_bytes;
  logic [flpa_pkg::ALIGN_W-1:0]       align_log2;
  logic [flpa_pkg::ADDR_W-1:0]        release_address;
  modport source (output valid, mode, request_bytes, align_log2, release_address,
                  input ready);
  modport sink   (input valid, mode, request_bytes, align_log2, release_address,
                  output ready);
endinterface

interface flpa_out_if;
  logic                          valid;
  logic                          ready;
  logic [flpa_pkg::ADDR_W-1:0]   data_address;
  logic [flpa_pkg::STATUS_W-1:0] status;
  logic [flpa_pkg::SIZE_W-1:0]   used_bytes;
  logic [flpa_pkg::SIZE_W-1:0]   peak_bytes;
  modport source (output valid, data_address, status, used_bytes, peak_bytes,
                  input ready);
  modport sink   (input valid, data_address, status, used_bytes, peak_bytes,
                  output ready);
endinterface
`default_nettype wire

FILE: design/flpa_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module flpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

FILE: design/flpa_ctrl.sv
// Sequencing state machine of the allocator.
`default_nettype none
module flpa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [flpa_pkg::MODE_W-1:0] in_mode,
  output logic                        in_ready,
  input  flpa_pkg::flpa_sts_t         sts,
  output flpa_pkg::flpa_cmd_t         cmd
);
  flpa_pkg::flpa_state_t state_r, state_nxt;
  logic                  op_free_r, op_free_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= flpa_pkg::S_INIT;
      op_free_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      op_free_r <= op_free_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    op_free_nxt = op_free_r;
    cmd         = '0;
    cmd.status  = flpa_pkg::ST_OK;
    in_ready    = 1'b0;
    case (state_r)
      flpa_pkg::S_INIT: begin
        cmd.init_pool = 1'b1;
        state_nxt     = flpa_pkg::S_IDLE;
      end
      flpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          op_free_nxt  = (in_mode == flpa_pkg::MODE_FREE);
          case (flpa_pkg::flpa_mode_t'(in_mode))
            flpa_pkg::MODE_ALLOC:   state_nxt = flpa_pkg::S_A_CHK;
            flpa_pkg::MODE_FREE: begin
              cmd.look_start = 1'b1;
              state_nxt      = flpa_pkg::S_F_LOOK;
            end
            flpa_pkg::MODE_RESTORE: state_nxt = flpa_pkg::S_RESTORE;
            default:                state_nxt = flpa_pkg::S_DONE;
          endcase
        end
      end
      flpa_pkg::S_A_CHK: begin
        if (sts.req_small) begin
          cmd.set_status = 1'b1;
          cmd.status     = flpa_pkg::ST_SMALL;
          state_nxt      = flpa_pkg::S_DONE;
        end else if (sts.alloc_full) begin
          cmd.set_status = 1'b1;
          cmd.status     = flpa_pkg::ST_FULL;
          state_nxt      = flpa_pkg::S_DONE;
        end else begin
          cmd.fit_start = 1'b1;
          state_nxt     = flpa_pkg::S_A_SCAN;
        end
      end
      flpa_pkg::S_A_SCAN: begin
        cmd.fit_run = 1'b1;
        if (sts.fit_done) begin
          if (sts.fit_ok) begin
            state_nxt = flpa_pkg::S_A_SPLIT;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = flpa_pkg::ST_NOFIT;
            state_nxt      = flpa_pkg::S_DONE;
          end
        end
      end
      flpa_pkg::S_A_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = sts.left_zero ? flpa_pkg::S_SHDN : flpa_pkg::S_A_REC;
      end
      flpa_pkg::S_SHDN: begin
        cmd.shdn_run = 1'b1;
        if (sts.shdn_done) begin
          state_nxt = op_free_r ? flpa_pkg::S_F_FIN : flpa_pkg::S_A_REC;
        end
      end
      flpa_pkg::S_A_REC: begin
        cmd.rec_wr = 1'b1;
        state_nxt  = flpa_pkg::S_DONE;
      end
      flpa_pkg::S_F_LOOK: begin
        cmd.look_run = 1'b1;
        if (sts.look_done) begin
          if (sts.look_hit) begin
            cmd.pos_start = 1'b1;
            state_nxt     = flpa_pkg::S_F_POS;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = flpa_pkg::ST_UNKNOWN;
            state_nxt      = flpa_pkg::S_DONE;
          end
        end
      end
      flpa_pkg::S_F_POS: begin
        cmd.pos_run = 1'b1;
        if (sts.pos_done) begin
          state_nxt = flpa_pkg::S_F_MERGE;
        end
      end
      flpa_pkg::S_F_MERGE: begin
        if (sts.mprev && sts.mnext) begin
          cmd.merge_both = 1'b1;
          state_nxt      = flpa_pkg::S_SHDN;
        end else if (sts.mprev) begin
          cmd.merge_prev = 1'b1;
          state_nxt      = flpa_pkg::S_F_FIN;
        end else if (sts.mnext) begin
          cmd.merge_next = 1'b1;
          state_nxt      = flpa_pkg::S_F_FIN;
        end else if (sts.free_full) begin
          cmd.set_status = 1'b1;
          cmd.status     = flpa_pkg::ST_FULL;
          state_nxt      = flpa_pkg::S_DONE;
        end else begin
          cmd.shup_setup = 1'b1;
          state_nxt      = flpa_pkg::S_SHUP;
        end
      end
      flpa_pkg::S_SHUP: begin
        cmd.shup_run = 1'b1;
        if (sts.shup_done) begin
          state_nxt = flpa_pkg::S_F_INS;
        end
      end
      flpa_pkg::S_F_INS: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = flpa_pkg::S_F_FIN;
      end
      flpa_pkg::S_F_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = flpa_pkg::S_DONE;
      end
      flpa_pkg::S_RESTORE: begin
        cmd.init_pool = 1'b1;
        state_nxt     = flpa_pkg::S_DONE;
      end
      flpa_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = flpa_pkg::S_IDLE;
        end
      end
      default: state_nxt = flpa_pkg::S_INIT;
    endcase
  end
endmodule
`default_nettype wire

FILE: design/flpa_dp.sv
// Datapath: free and allocation tables, scan pipelines, totals and result register.
`default_nettype none
module flpa_dp #(
  parameter int MAX_FREE_BLOCKS = flpa_pkg::DEF_MAX_FREE_BLOCKS,
  parameter int MAX_ALLOCATIONS = flpa_pkg::DEF_MAX_ALLOCATIONS,
  parameter int HEADER_BYTES    = flpa_pkg::DEF_HEADER_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  flpa_pkg::flpa_cmd_t             cmd,
  output flpa_pkg::flpa_sts_t             sts,
  input  logic [flpa_pkg::REQ_W-1:0]      in_request_bytes,
  input  logic [flpa_pkg::ALIGN_W-1:0]    in_align_log2,
  input  logic [flpa_pkg::ADDR_W-1:0]     in_release_address,
  input  logic                            cfg_we,
  input  logic [flpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [flpa_pkg::ADDR_W-1:0]     out_data_address,
  output logic [flpa_pkg::STATUS_W-1:0]   out_status,
  output logic [flpa_pkg::SIZE_W-1:0]     out_used_bytes,
  output logic [flpa_pkg::SIZE_W-1:0]     out_peak_bytes
);
  localparam int FI = MAX_FREE_BLOCKS > 1 ? $clog2(MAX_FREE_BLOCKS) : 1;
  localparam int FC = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int AI = MAX_ALLOCATIONS > 1 ? $clog2(MAX_ALLOCATIONS) : 1;
  localparam int AC = $clog2(MAX_ALLOCATIONS + 1);
  localparam int AW = flpa_pkg::ADDR_W;
  localparam int SW = flpa_pkg::SIZE_W;
  localparam int PW = flpa_pkg::PAD_W;
  localparam logic [FC-1:0] FMAX = FC'(MAX_FREE_BLOCKS);
  localparam logic [AC-1:0] AMAX = AC'(MAX_ALLOCATIONS);
  localparam logic [PW-1:0] HDR  = PW'(HEADER_BYTES);

  // configuration
  logic          policy_r;
  logic [SW-1:0] pool_r;
  logic [SW-1:0] pool_lim;

  // latched request
  logic [flpa_pkg::REQ_W-1:0]   req_r;
  logic [flpa_pkg::ALIGN_W-1:0] lg_r;
  logic [AW-1:0]                rel_r;

  // table bookkeeping
  logic [FC-1:0]              fcnt_r;
  logic [AC-1:0]              acnt_r;
  logic [MAX_ALLOCATIONS-1:0] valid_r;
  logic [SW-1:0]              used_r, peak_r, used_sum;

  // RAM ports
  logic                   fr_we;
  logic [FI-1:0]          fr_waddr, fr_raddr;
  flpa_pkg::flpa_fentry_t fr_wdata, fr_rdata;
  logic                   ar_we;
  flpa_pkg::flpa_aentry_t ar_wdata, ar_rdata;

  // free table scan (fit and position)
  logic [FC-1:0] fiss_r;
  logic          f_p1_v_r;
  logic [FI-1:0] f_p1_idx_r;
  logic          f_issue;
  logic [PW-1:0] s1_pad;

  logic          p2_v_r;
  logic [FI-1:0] p2_idx_r;
  logic [AW-1:0] p2_start_r;
  logic [SW-1:0] p2_size_r, p2_need_r;
  logic [PW-1:0] p2_pad_r;
  logic          p2_fits;
  logic [SW-1:0] p2_left;

  logic          stop_r, best_v_r;
  logic [FI-1:0] best_idx_r;
  logic [AW-1:0] best_start_r;
  logic [SW-1:0] best_left_r, best_need_r;
  logic [PW-1:0] best_pad_r;

  logic          slot_found_r;
  logic [AI-1:0] slot_r;

  // allocation lookup
  logic [AC-1:0] aiss_r;
  logic          a_p1_v_r;
  logic [AI-1:0] a_p1_idx_r;
  logic          a_issue;
  logic          hit_r;
  logic [AI-1:0] k_r;
  logic [AW-1:0] s_r;
  logic [SW-1:0] z_r, se_r;

  // insertion position
  logic          pos_found_r, prev_v_r;
  logic [FI-1:0] p_r, prev_idx_r;
  logic [AW-1:0] cur_start_r, prev_start_r;
  logic [SW-1:0] cur_size_r, prev_size_r, prev_end_r;
  logic [FC-1:0] p_eff;

  // shift engine
  logic [FC-1:0] sh_r;
  logic          pend_r;
  logic [FC-1:0] pidx_r;
  logic          sh_issue;

  // result
  logic                          out_valid_r;
  logic [AW-1:0]                 res_addr_r, out_addr_r;
  flpa_pkg::flpa_status_t        res_status_r;
  logic [flpa_pkg::STATUS_W-1:0] out_status_r;
  logic [SW-1:0]                 out_used_r, out_peak_r;

  flpa_ram #(.WIDTH($bits(flpa_pkg::flpa_fentry_t)), .DEPTH(MAX_FREE_BLOCKS)) u_free_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  flpa_ram #(.WIDTH($bits(flpa_pkg::flpa_aentry_t)), .DEPTH(MAX_ALLOCATIONS)) u_alloc_ram (
    .clk   (clk),
    .we    (ar_we),
    .waddr (slot_r),
    .wdata (ar_wdata),
    .raddr (aiss_r[AI-1:0]),
    .rdata (ar_rdata)
  );

  assign pool_lim = (pool_r < flpa_pkg::POOL_MIN) ? flpa_pkg::POOL_MIN :
                    (pool_r > flpa_pkg::POOL_MAX) ? flpa_pkg::POOL_MAX : pool_r;

  assign f_issue  = ((cmd.fit_run && !stop_r) || (cmd.pos_run && !pos_found_r)) &&
                    (fiss_r < fcnt_r);
  assign a_issue  = cmd.look_run && !hit_r && (aiss_r < AMAX);
  assign sh_issue = (cmd.shdn_run && (sh_r < fcnt_r)) || (cmd.shup_run && (sh_r > p_eff));
  assign s1_pad   = flpa_pkg::flpa_pad(fr_rdata.start, lg_r, HDR);
  assign p2_fits  = p2_size_r >= p2_need_r;
  assign p2_left  = p2_size_r - p2_need_r;
  assign p_eff    = pos_found_r ? FC'(p_r) : fcnt_r;
  assign used_sum = used_r + best_need_r;

  // free RAM read address
  always_comb begin
    if (cmd.shdn_run) begin
      fr_raddr = sh_r[FI-1:0];
    end else if (cmd.shup_run) begin
      fr_raddr = FI'(sh_r - FC'(1));
    end else begin
      fr_raddr = fiss_r[FI-1:0];
    end
  end

  // free RAM write port
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = '0;
    fr_wdata = fr_rdata;
    if (cmd.init_pool) begin
      fr_we          = 1'b1;
      fr_wdata.start = '0;
      fr_wdata.size  = pool_lim;
    end else if (cmd.split) begin
      fr_we          = best_left_r != '0;
      fr_waddr       = best_idx_r;
      fr_wdata.start = best_start_r + best_need_r[AW-1:0];
      fr_wdata.size  = best_left_r;
    end else if ((cmd.shdn_run || cmd.shup_run) && pend_r) begin
      fr_we    = 1'b1;
      fr_waddr = cmd.shdn_run ? FI'(pidx_r - FC'(1)) : pidx_r[FI-1:0];
    end else if (cmd.merge_both) begin
      fr_we          = 1'b1;
      fr_waddr       = prev_idx_r;
      fr_wdata.start = prev_start_r;
      fr_wdata.size  = prev_size_r + z_r + cur_size_r;
    end else if (cmd.merge_prev) begin
      fr_we          = 1'b1;
      fr_waddr       = prev_idx_r;
      fr_wdata.start = prev_start_r;
      fr_wdata.size  = prev_size_r + z_r;
    end else if (cmd.merge_next) begin
      fr_we          = 1'b1;
      fr_waddr       = p_r;
      fr_wdata.start = s_r;
      fr_wdata.size  = cur_size_r + z_r;
    end else if (cmd.ins_wr) begin
      fr_we          = 1'b1;
      fr_waddr       = p_eff[FI-1:0];
      fr_wdata.start = s_r;
      fr_wdata.size  = z_r;
    end
  end

  assign ar_we          = cmd.rec_wr;
  assign ar_wdata.data  = best_start_r + AW'(best_pad_r);
  assign ar_wdata.start = best_start_r;
  assign ar_wdata.size  = best_need_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= 1'b0;
      pool_r       <= flpa_pkg::POOL_MAX;
      fcnt_r       <= '0;
      acnt_r       <= '0;
      valid_r      <= '0;
      used_r       <= '0;
      peak_r       <= '0;
      f_p1_v_r     <= 1'b0;
      p2_v_r       <= 1'b0;
      stop_r       <= 1'b0;
      best_v_r     <= 1'b0;
      slot_found_r <= 1'b0;
      a_p1_v_r     <= 1'b0;
      hit_r        <= 1'b0;
      pos_found_r  <= 1'b0;
      prev_v_r     <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      res_status_r <= flpa_pkg::ST_OK;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          flpa_pkg::CFG_FIT_POLICY: policy_r <= cfg_wdata[0];
          flpa_pkg::CFG_POOL_BYTES: pool_r   <= cfg_wdata;
          default: ;
        endcase
      end

      if (cmd.latch_in) begin
        res_status_r <= flpa_pkg::ST_OK;
      end else if (cmd.set_status) begin
        res_status_r <= cmd.status;
      end

      if (cmd.init_pool) begin
        fcnt_r  <= FC'(1);
        acnt_r  <= '0;
        valid_r <= '0;
        used_r  <= '0;
        peak_r  <= '0;
      end

      // fit scan with slot search alongside
      if (cmd.fit_start) begin
        stop_r       <= 1'b0;
        best_v_r     <= 1'b0;
        p2_v_r       <= 1'b0;
        slot_found_r <= 1'b0;
      end else if (cmd.fit_run) begin
        p2_v_r <= f_p1_v_r && !stop_r;
        if (p2_v_r && !stop_r && p2_fits) begin
          if (!best_v_r || (p2_left < best_left_r)) begin
            best_v_r <= 1'b1;
          end
          if (!policy_r) begin
            stop_r <= 1'b1;
          end
        end
        if (!slot_found_r && !valid_r[slot_r]) begin
          slot_found_r <= 1'b1;
        end
      end

      if (cmd.fit_start || cmd.pos_start) begin
        f_p1_v_r <= 1'b0;
      end else begin
        f_p1_v_r <= f_issue;
      end

      if (cmd.look_start) begin
        a_p1_v_r <= 1'b0;
        hit_r    <= 1'b0;
      end else begin
        a_p1_v_r <= a_issue;
        if (cmd.look_run && a_p1_v_r && !hit_r && valid_r[a_p1_idx_r] &&
            (ar_rdata.data == rel_r)) begin
          hit_r <= 1'b1;
        end
      end

      if (cmd.pos_start) begin
        pos_found_r <= 1'b0;
        prev_v_r    <= 1'b0;
      end else if (cmd.pos_run && f_p1_v_r && !pos_found_r) begin
        if (fr_rdata.start > s_r) begin
          pos_found_r <= 1'b1;
        end else begin
          prev_v_r <= 1'b1;
        end
      end

      if (cmd.split || cmd.merge_both || cmd.shup_setup) begin
        pend_r <= 1'b0;
      end else begin
        pend_r <= sh_issue;
      end
      if (cmd.shdn_run && !sh_issue && !pend_r) begin
        fcnt_r <= fcnt_r - FC'(1);
      end
      if (cmd.ins_wr) begin
        fcnt_r <= fcnt_r + FC'(1);
      end

      if (cmd.rec_wr) begin
        valid_r[slot_r] <= 1'b1;
        acnt_r          <= acnt_r + AC'(1);
        used_r          <= used_sum;
        if (used_sum > peak_r) begin
          peak_r <= used_sum;
        end
      end
      if (cmd.fin) begin
        valid_r[k_r] <= 1'b0;
        acnt_r       <= acnt_r - AC'(1);
        used_r       <= (used_r >= z_r) ? used_r - z_r : '0;
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r      <= in_request_bytes;
      lg_r       <= (in_align_log2 > flpa_pkg::MAX_ALIGN_LOG2) ?
                    flpa_pkg::MAX_ALIGN_LOG2 : in_align_log2;
      rel_r      <= in_release_address;
      res_addr_r <= '0;
    end else if (cmd.rec_wr) begin
      res_addr_r <= ar_wdata.data;
    end

    if (cmd.fit_start || cmd.pos_start) begin
      fiss_r <= '0;
    end else if (f_issue) begin
      fiss_r <= fiss_r + FC'(1);
    end
    f_p1_idx_r <= fiss_r[FI-1:0];

    // stage 1: padding and block need
    p2_idx_r   <= f_p1_idx_r;
    p2_start_r <= fr_rdata.start;
    p2_size_r  <= fr_rdata.size;
    p2_pad_r   <= s1_pad;
    p2_need_r  <= SW'(req_r) + SW'(s1_pad);

    // stage 2: candidate selection
    if (cmd.fit_run && p2_v_r && !stop_r && p2_fits &&
        (!best_v_r || (p2_left < best_left_r))) begin
      best_idx_r   <= p2_idx_r;
      best_start_r <= p2_start_r;
      best_left_r  <= p2_left;
      best_need_r  <= p2_need_r;
      best_pad_r   <= p2_pad_r;
    end

    if (cmd.fit_start) begin
      slot_r <= '0;
    end else if (cmd.fit_run && !slot_found_r && valid_r[slot_r]) begin
      slot_r <= slot_r + AI'(1);
    end

    if (cmd.look_start) begin
      aiss_r <= '0;
    end else if (a_issue) begin
      aiss_r <= aiss_r + AC'(1);
    end
    a_p1_idx_r <= aiss_r[AI-1:0];
    if (cmd.look_run && a_p1_v_r && !hit_r && valid_r[a_p1_idx_r] &&
        (ar_rdata.data == rel_r)) begin
      k_r  <= a_p1_idx_r;
      s_r  <= ar_rdata.start;
      z_r  <= ar_rdata.size;
      se_r <= SW'(ar_rdata.start) + ar_rdata.size;
    end

    if (cmd.pos_run && f_p1_v_r && !pos_found_r) begin
      if (fr_rdata.start > s_r) begin
        p_r         <= f_p1_idx_r;
        cur_start_r <= fr_rdata.start;
        cur_size_r  <= fr_rdata.size;
      end else begin
        prev_idx_r   <= f_p1_idx_r;
        prev_start_r <= fr_rdata.start;
        prev_size_r  <= fr_rdata.size;
        prev_end_r   <= SW'(fr_rdata.start) + fr_rdata.size;
      end
    end

    // shift engine: down removes an entry, up opens a gap
    if (cmd.split) begin
      sh_r <= FC'(best_idx_r) + FC'(1);
    end else if (cmd.merge_both) begin
      sh_r <= p_eff + FC'(1);
    end else if (cmd.shup_setup) begin
      sh_r <= fcnt_r;
    end else if (sh_issue) begin
      sh_r <= cmd.shdn_run ? sh_r + FC'(1) : sh_r - FC'(1);
    end
    pidx_r <= sh_r;

    if (cmd.emit) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
      out_used_r   <= used_r;
      out_peak_r   <= peak_r;
    end
  end

  always_comb begin
    sts.req_small  = req_r < flpa_pkg::MIN_REQUEST;
    sts.alloc_full = acnt_r == AMAX;
    sts.fit_done   = slot_found_r &&
                     (stop_r || ((fiss_r >= fcnt_r) && !f_p1_v_r && !p2_v_r));
    sts.fit_ok     = best_v_r;
    sts.left_zero  = best_left_r == '0;
    sts.shdn_done  = (sh_r >= fcnt_r) && !pend_r;
    sts.look_done  = hit_r || ((aiss_r >= AMAX) && !a_p1_v_r);
    sts.look_hit   = hit_r;
    sts.pos_done   = pos_found_r || ((fiss_r >= fcnt_r) && !f_p1_v_r);
    sts.mprev      = prev_v_r && (prev_end_r == SW'(s_r));
    sts.mnext      = pos_found_r && (se_r == SW'(cur_start_r));
    sts.free_full  = fcnt_r >= FMAX;
    sts.shup_done  = (sh_r <= p_eff) && !pend_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_data_address = out_addr_r;
  assign out_status       = out_status_r;
  assign out_used_bytes   = out_used_r;
  assign out_peak_bytes   = out_peak_r;
endmodule
`default_nettype wire

FILE: design/free_list_pool_allocator.sv
// Free-list pool allocator: one request at a time, result held in an output register.
// Flow, accept to result valid: an allocate checks the request, scans the free table (to the
//   end for best fit, to the first fitting block for first fit, until a free allocation slot
//   is found too), splits the block and records it; a used-up block also shifts entries down.
//   A free looks up its allocation, finds the insertion point, then merges, shifts and inserts.
// Throughput: the next request is taken the cycle after the result is loaded. Reset: rst_n.
`default_nettype none
module free_list_pool_allocator #(
  parameter int MAX_FREE_BLOCKS = flpa_pkg::DEF_MAX_FREE_BLOCKS,
  parameter int MAX_ALLOCATIONS = flpa_pkg::DEF_MAX_ALLOCATIONS,
  parameter int HEADER_BYTES    = flpa_pkg::DEF_HEADER_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  flpa_in_if.sink                         in_req,
  flpa_out_if.source                      out_rsp,
  input  logic                            cfg_we,
  input  logic [flpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  flpa_pkg::flpa_cmd_t cmd;
  flpa_pkg::flpa_sts_t sts;

  flpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_mode  (in_req.mode),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  flpa_dp #(
    .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
    .MAX_ALLOCATIONS (MAX_ALLOCATIONS),
    .HEADER_BYTES    (HEADER_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_request_bytes   (in_req.request_bytes),
    .in_align_log2      (in_req.align_log2),
    .in_release_address (in_req.release_address),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_rsp.valid),
    .out_ready          (out_rsp.ready),
    .out_data_address   (out_rsp.data_address),
    .out_status         (out_rsp.status),
    .out_used_bytes     (out_rsp.used_bytes),
    .out_peak_bytes     (out_rsp.peak_bytes)
  );

  // one request in flight: no new request right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request taken while another is in flight");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_rsp.valid)
    else $error("result not presented after emit");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_rsp.valid) |-> $past(cmd.emit))
    else $error("result valid without emit");

  a_single_write_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.split, cmd.merge_both, cmd.merge_prev, cmd.merge_next,
                cmd.ins_wr, cmd.init_pool}) <= 1)
    else $error("conflicting free table writes");
endmodule
`default_nettype wire

FILE: test/tb_flpa_sb.sv
// Scoreboard for the free-list pool allocator: predicts and checks each result.
`timescale 1ns / 1ps
class flpa_scoreboard;
  typedef struct packed {
    logic [15:0] addr;
    logic [2:0]  status;
    logic [16:0] used;
    logic [16:0] peak;
  } rsp_t;

  bit [0:0]  fit_best;
  bit [16:0] pool_cfg;
  bit [16:0] fstart[32];
  bit [17:0] fsize[32];
  int        fcount;
  bit [15:0] adata[32];
  bit [15:0] astart[32];
  bit [17:0] asize[32];
  bit        avalid[32];
  bit [17:0] used_tot;
  bit [17:0] peak_tot;
  rsp_t      pending_rsp[$];
  int        errors;
  int        checked;
  int        n_ok, n_small, n_nofit, n_unknown, n_full;

  function new();
    fit_best = 0;
    pool_cfg = 17'd65536;
    errors = 0;
    checked = 0;
    restore_pool();
  endfunction

  function void restore_pool();
    bit [17:0] lim;
    lim = 18'(pool_cfg);
    if (lim < 16) lim = 16;
    if (lim > 65536) lim = 65536;
    for (int i = 0; i < 32; i++) begin
      fstart[i] = 0; fsize[i] = 0; avalid[i] = 0;
    end
    fsize[0] = lim;
    fcount = 1;
    used_tot = 0;
    peak_tot = 0;
  endfunction

  function void write_reg(bit idx, bit [16:0] val);
    if (idx == flpa_pkg::CFG_FIT_POLICY) fit_best = val[0];
    else pool_cfg = val;
  endfunction

  function bit [17:0] pad_of(bit [16:0] start, int lg);
    bit [17:0] a, pad;
    a = 18'd1 << lg;
    pad = a - (start & (a - 1));
    if (pad < 8) pad += a * ((8 - pad + a - 1) >> lg);
    return pad;
  endfunction

  function void drop_free(int i);
    for (int j = i; j + 1 < fcount; j++) begin
      fstart[j] = fstart[j+1]; fsize[j] = fsize[j+1];
    end
    if (fcount > 0) fcount--;
  endfunction

  function flpa_pkg::flpa_status_t alloc(bit [15:0] req, bit [3:0] lg_in, output bit [15:0] addr);
    int slot, best, lg;
    bit [17:0] best_left, best_pad, pad, need, left;
    bit [16:0] s;
    addr = 0;
    slot = -1; best = -1; best_left = 0; best_pad = 0;
    if (req < 8) return flpa_pkg::ST_SMALL;
    for (int i = 0; i < 32; i++) if (!avalid[i]) begin slot = i; break; end
    if (slot < 0) return flpa_pkg::ST_FULL;
    lg = (lg_in > 8) ? 8 : lg_in;
    for (int i = 0; i < fcount; i++) begin
      pad = pad_of(fstart[i], lg);
      need = req + pad;
      if (fsize[i] >= need) begin
        left = fsize[i] - need;
        if (best < 0 || left < best_left) begin
          best = i; best_left = left; best_pad = pad;
        end
        if (!fit_best) break;
      end
    end
    if (best < 0) return flpa_pkg::ST_NOFIT;
    s = fstart[best];
    need = req + best_pad;
    if (best_left > 0) begin
      fstart[best] = 17'(s + need); fsize[best] = best_left;
    end else drop_free(best);
    avalid[slot] = 1;
    astart[slot] = 16'(s);
    asize[slot] = need;
    adata[slot] = 16'(s + best_pad);
    addr = 16'(s + best_pad);
    used_tot += need;
    if (used_tot > peak_tot) peak_tot = used_tot;
    return flpa_pkg::ST_OK;
  endfunction

  function flpa_pkg::flpa_status_t release_blk(bit [15:0] a);
    int k, p;
    bit [17:0] s, z;
    bit mp, mn;
    k = -1;
    for (int i = 0; i < 32; i++)
      if (avalid[i] && adata[i] == a) begin k = i; break; end
    if (k < 0) return flpa_pkg::ST_UNKNOWN;
    s = 18'(astart[k]); z = asize[k];
    p = fcount;
    for (int i = 0; i < fcount; i++) if (fstart[i] > s) begin p = i; break; end
    mp = (p > 0) && (fstart[p-1] + fsize[p-1] == s);
    mn = (p < fcount) && (s + z == fstart[p]);
    if (mp && mn) begin
      fsize[p-1] += z + fsize[p];
      drop_free(p);
    end else if (mp) fsize[p-1] += z;
    else if (mn) begin
      fstart[p] = 17'(s); fsize[p] += z;
    end else begin
      if (fcount >= 32) return flpa_pkg::ST_FULL;
      for (int i = fcount; i > p; i--) begin
        fstart[i] = fstart[i-1]; fsize[i] = fsize[i-1];
      end
      fstart[p] = 17'(s); fsize[p] = z;
      fcount++;
    end
    avalid[k] = 0;
    used_tot = (used_tot >= z) ? used_tot - z : 0;
    return flpa_pkg::ST_OK;
  endfunction

  // A random live data address, for well-formed frees.
  function bit [15:0] live_addr();
    int idx[$];
    for (int i = 0; i < 32; i++) if (avalid[i]) idx.push_back(i);
    if (idx.size() == 0) return 16'($urandom);
    return adata[idx[$urandom_range(idx.size() - 1)]];
  endfunction

  function void note_request(bit [1:0] mode, bit [15:0] req, bit [3:0] lg, bit [15:0] ra);
    rsp_t r;
    flpa_pkg::flpa_status_t st;
    bit [15:0] a;
    a = 0;
    st = flpa_pkg::ST_OK;
    case (mode)
      flpa_pkg::MODE_ALLOC: st = alloc(req, lg, a);
      flpa_pkg::MODE_FREE: st = release_blk(ra);
      flpa_pkg::MODE_RESTORE: restore_pool();
      default: ;
    endcase
    case (st)
      flpa_pkg::ST_OK: n_ok++;
      flpa_pkg::ST_SMALL: n_small++;
      flpa_pkg::ST_NOFIT: n_nofit++;
      flpa_pkg::ST_UNKNOWN: n_unknown++;
      default: n_full++;
    endcase
    r.addr = a; r.status = st; r.used = used_tot[16:0]; r.peak = peak_tot[16:0];
    pending_rsp.push_back(r);
  endfunction

  function void check_result(bit [15:0] a, bit [2:0] st, bit [16:0] u, bit [16:0] pk);
    rsp_t e;
    if (pending_rsp.size() == 0) begin
      $display("%0t: unexpected result addr=%0d status=%0d", $time, a, st);
      errors++;
      return;
    end
    e = pending_rsp.pop_front();
    checked++;
    if (a !== e.addr) begin
      $display("%0t: data_address exp %0d got %0d", $time, e.addr, a); errors++;
    end
    if (st !== e.status) begin
      $display("%0t: status exp %0d got %0d", $time, e.status, st); errors++;
    end
    if (u !== e.used) begin
      $display("%0t: used_bytes exp %0d got %0d", $time, e.used, u); errors++;
    end
    if (pk !== e.peak) begin
      $display("%0t: peak_bytes exp %0d got %0d", $time, e.peak, pk); errors++;
    end
  endfunction
endclass

FILE: test/tb_top.sv
// Top-level testbench of the free-list pool allocator.
`timescale 1ns / 1ps
module tb_top;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [flpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [flpa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  flpa_in_if  in_ch();
  flpa_out_if out_ch();

  free_list_pool_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_ch.sink), .out_rsp(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  flpa_scoreboard alloc_sb = new();
  int cycles = 0;
  int sent = 0;
  int idle_pct = 24;
  bit hold_off = 0;
  int hold_cycles = 0;
  bit hold_done = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.mode = '0;
    in_ch.request_bytes = '0;
    in_ch.align_log2 = '0;
    in_ch.release_address = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready)
      alloc_sb.check_result(out_ch.data_address, out_ch.status,
                            out_ch.used_bytes, out_ch.peak_bytes);
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  always @(negedge clk) begin
    if (hold_off) begin
      out_ch.ready <= 0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 400) begin
        hold_off <= 0; hold_done <= 1;
      end
    end else
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send_request(bit [1:0] mode, bit [15:0] req, bit [3:0] lg, bit [15:0] ra);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_ch.valid = 1;
    in_ch.mode = mode;
    in_ch.request_bytes = req;
    in_ch.align_log2 = lg;
    in_ch.release_address = ra;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    alloc_sb.note_request(mode, req, lg, ra);
    sent++;
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic write_reg(bit [flpa_pkg::CFG_IDX_W-1:0] idx,
                           bit [flpa_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    alloc_sb.write_reg(idx, val);
  endtask

  task automatic drain();
    while (alloc_sb.pending_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    bit [15:0] req;
    r = $urandom_range(99);
    if ($urandom_range(3) == 0) req = 16'($urandom);
    else req = 16'($urandom_range(300, 8));
    if (r < 50)
      send_request(flpa_pkg::MODE_ALLOC, req, 4'($urandom_range(15)), 16'($urandom));
    else if (r < 88)
      send_request(flpa_pkg::MODE_FREE, 16'($urandom), 4'($urandom), alloc_sb.live_addr());
    else if (r < 94)
      send_request(flpa_pkg::MODE_FREE, 16'($urandom), 4'($urandom), 16'($urandom));
    else if (r < 97)
      send_request(flpa_pkg::MODE_ALLOC, 16'($urandom_range(7)), 4'($urandom), 16'($urandom));
    else if (r < 99)
      send_request(flpa_pkg::MODE_RESTORE, 16'($urandom), 4'($urandom), 16'($urandom));
    else send_request(flpa_pkg::MODE_NOP, 16'($urandom), 4'($urandom), 16'($urandom));
  endtask

  initial begin
    bit [16:0] pools[4];
    pools = '{17'd65536, 17'd16, 17'd1024, 17'd131071};
    repeat (7) @(negedge clk);
    rst_n <= 1;
    repeat (3) @(negedge clk);

    // Directed: extremes, every mode, and every status but full.
    send_request(flpa_pkg::MODE_ALLOC, 16'd7, 4'd0, 16'd0);
    send_request(flpa_pkg::MODE_ALLOC, 16'd8, 4'd0, 16'd0);
    send_request(flpa_pkg::MODE_ALLOC, 16'd100, 4'd8, 16'd0);
    send_request(flpa_pkg::MODE_ALLOC, 16'd20, 4'd15, 16'd0);
    send_request(flpa_pkg::MODE_ALLOC, 16'hFFFF, 4'd3, 16'd0);
    send_request(flpa_pkg::MODE_FREE, 16'd0, 4'd0, 16'hFFFF);
    send_request(flpa_pkg::MODE_FREE, 16'd0, 4'd0, alloc_sb.live_addr());
    send_request(flpa_pkg::MODE_FREE, 16'd0, 4'd0, alloc_sb.live_addr());
    send_request(flpa_pkg::MODE_NOP, 16'hFFFF, 4'hF, 16'hFFFF);
    send_request(flpa_pkg::MODE_RESTORE, 16'd0, 4'd0, 16'd0);
    // Fill the allocation table, then free every other one to fragment.
    for (int i = 0; i < 33; i++) send_request(flpa_pkg::MODE_ALLOC, 16'd8, 4'd2, 16'd0);
    drain();
    for (int i = 0; i < 32; i += 2)
      send_request(flpa_pkg::MODE_FREE, 16'd0, 4'd0, alloc_sb.adata[i]);
    send_request(flpa_pkg::MODE_ALLOC, 16'd40, 4'd4, 16'd0);
    send_request(flpa_pkg::MODE_RESTORE, 16'd0, 4'd0, 16'd0);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(flpa_pkg::CFG_FIT_POLICY, flpa_pkg::CFG_DATA_W'(ph & 1));
      write_reg(flpa_pkg::CFG_POOL_BYTES, pools[(ph >> 1) & 3]);
      send_request(flpa_pkg::MODE_RESTORE, 16'd0, 4'd0, 16'd0);
      if (ph == 3) idle_pct = 0;
      else idle_pct = 24;
      if (ph == 5) hold_off = 1;
      for (int i = 0; i < 190; i++) random_item();
    end
    idle_pct = 24;
    drain();
    while (!hold_done) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("sent %0d requests, checked %0d results, errors %0d", sent, alloc_sb.checked,
             alloc_sb.errors);
    $display("ok %0d small %0d nofit %0d unknown %0d full %0d", alloc_sb.n_ok,
             alloc_sb.n_small, alloc_sb.n_nofit, alloc_sb.n_unknown, alloc_sb.n_full);
    if (alloc_sb.errors == 0 && alloc_sb.pending_rsp.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: sim.f
design/flpa_pkg.sv
design/flpa_ifs.sv
design/flpa_ram.sv
design/flpa_ctrl.sv
design/flpa_dp.sv
design/free_list_pool_allocator.sv
test/tb_flpa_sb.sv
test/tb_top.sv
